// File: src/lifo_stack_with_reverse_top_defines.svh
// Assertion macros shared by the stack checker.
`ifndef LIFO_STACK_WITH_REVERSE_TOP_DEFINES_SVH
`define LIFO_STACK_WITH_REVERSE_TOP_DEFINES_SVH

// clocked check, off while reset is asserted
`define LSR_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// clocked check, also active during reset
`define LSR_ASSERT_RST(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: src/lsr_pkg.sv
// Shared types and constants of the LIFO stack with reverse.
package lsr_pkg;

	localparam int DEPTH_DEF      = 256;
	localparam int ELEM_BYTES_DEF = 4;

	localparam int CFG_W   = 9;
	localparam int VALUE_W = 32;
	localparam int COUNT_W = 9;
	localparam int ACT_W   = 2;

	localparam logic [CFG_W-1:0] CAP_RESET = 9'd256;

	localparam int S_TDATA_W = 32;
	localparam int S_TUSER_W = 2;
	localparam int M_TDATA_W = 80;
	localparam int M_TUSER_W = 8;

	typedef enum logic [ACT_W-1:0] {
		ACT_PUSH    = 2'd0,
		ACT_POP     = 2'd1,
		ACT_REVERSE = 2'd2
	} action_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_OVERFLOW  = 2'd1,
		ST_UNDERFLOW = 2'd2
	} status_t;

	typedef struct packed {
		logic [VALUE_W-1:0] pop_value;
		status_t            status;
		logic [VALUE_W-1:0] top_value;
		logic               top_valid;
		logic [COUNT_W-1:0] count;
	} res_t;

endpackage

// File: src/lifo_stack_with_reverse_top.sv
// Top level of the LIFO stack with reverse: stream ports, sequencer, memory, result buffer.
// Push, over/underflow, unused action, pop to empty, reverse of <2 entries: result on accept.
// Pop leaving entries: the new top is read back from the entry memory in S_POP.
// Reverse of n entries: one write port swaps a pair in two writes, S_WLO then S_WHI.
// Input is taken one beat at a time; a second result may wait in the skid entry.
// Reset (arst_n low, async): count cleared, capacity 256, buffer empty; memory not cleared.
module lifo_stack_with_reverse_top #(
	parameter int DEPTH      = lsr_pkg::DEPTH_DEF,
	parameter int ELEM_BYTES = lsr_pkg::ELEM_BYTES_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [lsr_pkg::CFG_W-1:0]     cfg_wdata,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [lsr_pkg::S_TDATA_W-1:0] s_tdata,  // [31:0] push_value
	input  logic [lsr_pkg::S_TUSER_W-1:0] s_tuser,  // [1:0] action
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [lsr_pkg::M_TDATA_W-1:0] m_tdata,  // [31:0] pop_value, [63:32] top_value,
	                                                // [72:64] count, [79:73] zero
	output logic [lsr_pkg::M_TUSER_W-1:0] m_tuser   // [1:0] status, [2] top_valid, [7:3] zero
);

	localparam int EW = 8 * ELEM_BYTES;
	localparam int AW = $clog2(DEPTH);

	logic          produce;
	logic          out_room;
	lsr_pkg::res_t res;
	lsr_pkg::res_t m_res;
	logic          mem_we;
	logic [AW-1:0] mem_waddr;
	logic [EW-1:0] mem_wdata;
	logic          mem_re;
	logic [AW-1:0] mem_raddr_a;
	logic [AW-1:0] mem_raddr_b;
	logic [EW-1:0] mem_rdata_a;
	logic [EW-1:0] mem_rdata_b;

	lsr_ctrl #(
		.DEPTH(DEPTH),
		.EW   (EW),
		.AW   (AW)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.in_valid   (s_tvalid),
		.in_ready   (s_tready),
		.in_action  (s_tuser),
		.in_value   (s_tdata),
		.out_room   (out_room),
		.produce    (produce),
		.res        (res),
		.mem_we     (mem_we),
		.mem_waddr  (mem_waddr),
		.mem_wdata  (mem_wdata),
		.mem_re     (mem_re),
		.mem_raddr_a(mem_raddr_a),
		.mem_raddr_b(mem_raddr_b),
		.mem_rdata_a(mem_rdata_a),
		.mem_rdata_b(mem_rdata_b)
	);

	lsr_ram #(
		.DEPTH(DEPTH),
		.DW   (EW),
		.AW   (AW)
	) u_ram (
		.clk    (clk),
		.we     (mem_we),
		.waddr  (mem_waddr),
		.wdata  (mem_wdata),
		.re     (mem_re),
		.raddr_a(mem_raddr_a),
		.raddr_b(mem_raddr_b),
		.rdata_a(mem_rdata_a),
		.rdata_b(mem_rdata_b)
	);

	lsr_out_buf u_out (
		.clk    (clk),
		.arst_n (arst_n),
		.produce(produce),
		.res    (res),
		.room   (out_room),
		.m_valid(m_tvalid),
		.m_ready(m_tready),
		.m_res  (m_res)
	);

	assign m_tdata = {7'd0, m_res.count, m_res.top_value, m_res.pop_value};
	assign m_tuser = {5'd0, m_res.top_valid, m_res.status};

endmodule

// File: src/lsr_ram.sv
// Entry memory: one write port, two registered read ports.
module lsr_ram #(
	parameter int DEPTH = lsr_pkg::DEPTH_DEF,
	parameter int DW    = 8 * lsr_pkg::ELEM_BYTES_DEF,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [DW-1:0] wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr_a,
	input  logic [AW-1:0] raddr_b,
	output logic [DW-1:0] rdata_a,
	output logic [DW-1:0] rdata_b
);

	logic [DW-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_a <= mem[raddr_a];
			rdata_b <= mem[raddr_b];
		end
	end

endmodule

// File: src/lsr_out_buf.sv
// Two-entry result buffer between the sequencer and the master side.
module lsr_out_buf (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          produce,
	input  lsr_pkg::res_t res,
	output logic          room,
	output logic          m_valid,
	input  logic          m_ready,
	output lsr_pkg::res_t m_res
);

	logic          main_v_q;
	logic          skid_v_q;
	lsr_pkg::res_t main_q;
	lsr_pkg::res_t skid_q;
	logic          take;

	assign take    = main_v_q && m_ready;
	assign m_valid = main_v_q;
	assign m_res   = main_q;
	assign room    = !skid_v_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_v_q <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (produce) begin
			if (!main_v_q || take) begin
				main_v_q <= 1'b1;
			end else begin
				skid_v_q <= 1'b1;
			end
		end else if (take) begin
			if (skid_v_q) begin
				skid_v_q <= 1'b0;
			end else begin
				main_v_q <= 1'b0;
			end
		end
	end

	// skid is empty whenever a new result is produced
	always_ff @(posedge clk) begin
		if (produce) begin
			if (!main_v_q || take) begin
				main_q <= res;
			end else begin
				skid_q <= res;
			end
		end else if (take && skid_v_q) begin
			main_q <= skid_q;
		end
	end

endmodule

// File: src/lsr_ctrl.sv
// Stack sequencer: fill count, cached top, pop refill and reverse swap loop.
module lsr_ctrl #(
	parameter int DEPTH = lsr_pkg::DEPTH_DEF,
	parameter int EW    = 8 * lsr_pkg::ELEM_BYTES_DEF,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [lsr_pkg::CFG_W-1:0]   cfg_wdata,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [lsr_pkg::ACT_W-1:0]   in_action,
	input  logic [lsr_pkg::VALUE_W-1:0] in_value,
	input  logic                        out_room,
	output logic                        produce,
	output lsr_pkg::res_t               res,
	output logic                        mem_we,
	output logic [AW-1:0]               mem_waddr,
	output logic [EW-1:0]               mem_wdata,
	output logic                        mem_re,
	output logic [AW-1:0]               mem_raddr_a,
	output logic [AW-1:0]               mem_raddr_b,
	input  logic [EW-1:0]               mem_rdata_a,
	input  logic [EW-1:0]               mem_rdata_b
);

	localparam int FW = $clog2(DEPTH + 1);
	localparam int CW = (FW > lsr_pkg::CFG_W) ? FW : lsr_pkg::CFG_W;

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_POP  = 4'b0010,
		S_WLO  = 4'b0100,
		S_WHI  = 4'b1000
	} state_t;

	state_t                    state_q, state_d;
	logic [FW-1:0]             fill_q, fill_d;
	logic [EW-1:0]             top_q, top_d;
	logic [AW-1:0]             lo_q, lo_d;
	logic [AW-1:0]             hi_q, hi_d;
	logic [lsr_pkg::CFG_W-1:0] cap_q;

	logic          accept;
	logic          full;
	logic [FW-1:0] fill_m1;
	logic [FW-1:0] fill_m2;
	logic [FW-1:0] fill_p1;
	logic [CW-1:0] fill_x;
	logic [63:0]   in_wide;
	logic [EW-1:0] in_elem;
	logic [AW-1:0] lo_n;
	logic [AW-1:0] hi_n;
	logic          first_pair;

	function automatic logic [lsr_pkg::VALUE_W-1:0] to_val(input logic [EW-1:0] e);
		logic [63:0] w;
		w = 64'(e);
		return w[lsr_pkg::VALUE_W-1:0];
	endfunction

	function automatic logic [lsr_pkg::COUNT_W-1:0] to_cnt(input logic [FW-1:0] f);
		logic [CW-1:0] w;
		w = CW'(f);
		return w[lsr_pkg::COUNT_W-1:0];
	endfunction

	assign in_ready   = (state_q == S_IDLE) && out_room;
	assign accept     = in_valid && in_ready;
	assign fill_m1    = fill_q - FW'(1);
	assign fill_m2    = fill_q - FW'(2);
	assign fill_p1    = fill_q + FW'(1);
	assign fill_x     = CW'(fill_q);
	assign full       = (fill_x >= CW'(cap_q)) || (fill_x >= CW'(DEPTH));
	assign in_wide    = 64'(in_value);
	assign in_elem    = in_wide[EW-1:0];
	assign lo_n       = lo_q + AW'(1);
	assign hi_n       = hi_q - AW'(1);
	assign first_pair = (hi_q == fill_m1[AW-1:0]);

	always_comb begin
		state_d     = state_q;
		fill_d      = fill_q;
		top_d       = top_q;
		lo_d        = lo_q;
		hi_d        = hi_q;
		produce     = 1'b0;
		mem_we      = 1'b0;
		mem_waddr   = '0;
		mem_wdata   = '0;
		mem_re      = 1'b0;
		mem_raddr_a = '0;
		mem_raddr_b = '0;

		res.pop_value = '0;
		res.status    = lsr_pkg::ST_OK;
		res.top_value = (fill_q != '0) ? to_val(top_q) : '0;
		res.top_valid = (fill_q != '0);
		res.count     = to_cnt(fill_q);

		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					unique case (lsr_pkg::action_t'(in_action))
						lsr_pkg::ACT_PUSH: begin
							produce = 1'b1;
							if (full) begin
								res.status = lsr_pkg::ST_OVERFLOW;
							end else begin
								mem_we        = 1'b1;
								mem_waddr     = fill_q[AW-1:0];
								mem_wdata     = in_elem;
								fill_d        = fill_p1;
								top_d         = in_elem;
								res.top_value = to_val(in_elem);
								res.top_valid = 1'b1;
								res.count     = to_cnt(fill_p1);
							end
						end
						lsr_pkg::ACT_POP: begin
							if (fill_q == '0) begin
								produce    = 1'b1;
								res.status = lsr_pkg::ST_UNDERFLOW;
							end else begin
								fill_d = fill_m1;
								if (fill_q == FW'(1)) begin
									produce       = 1'b1;
									res.pop_value = to_val(top_q);
									res.top_value = '0;
									res.top_valid = 1'b0;
									res.count     = '0;
								end else begin
									mem_re      = 1'b1;
									mem_raddr_a = fill_m2[AW-1:0];
									state_d     = S_POP;
								end
							end
						end
						lsr_pkg::ACT_REVERSE: begin
							if (fill_q < FW'(2)) begin
								produce = 1'b1;
							end else begin
								mem_re      = 1'b1;
								mem_raddr_a = '0;
								mem_raddr_b = fill_m1[AW-1:0];
								lo_d        = '0;
								hi_d        = fill_m1[AW-1:0];
								state_d     = S_WLO;
							end
						end
						default: begin
							produce = 1'b1;
						end
					endcase
				end
			end
			S_POP: begin
				// old top still cached; new top arrives from memory
				produce       = 1'b1;
				top_d         = mem_rdata_a;
				res.pop_value = to_val(top_q);
				res.top_value = to_val(mem_rdata_a);
				res.top_valid = 1'b1;
				state_d       = S_IDLE;
			end
			S_WLO: begin
				mem_we    = 1'b1;
				mem_waddr = lo_q;
				mem_wdata = mem_rdata_b;
				state_d   = S_WHI;
			end
			S_WHI: begin
				mem_we    = 1'b1;
				mem_waddr = hi_q;
				mem_wdata = mem_rdata_a;
				if (first_pair) begin
					top_d = mem_rdata_a;
				end
				if (lo_n < hi_n) begin
					mem_re      = 1'b1;
					mem_raddr_a = lo_n;
					mem_raddr_b = hi_n;
					lo_d        = lo_n;
					hi_d        = hi_n;
					state_d     = S_WLO;
				end else begin
					produce       = 1'b1;
					res.top_value = to_val(first_pair ? mem_rdata_a : top_q);
					res.top_valid = 1'b1;
					state_d       = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			fill_q  <= '0;
			cap_q   <= lsr_pkg::CAP_RESET;
		end else begin
			state_q <= state_d;
			fill_q  <= fill_d;
			if (cfg_we) begin
				cap_q <= cfg_wdata;
			end
		end
	end

	always_ff @(posedge clk) begin
		top_q <= top_d;
		lo_q  <= lo_d;
		hi_q  <= hi_d;
	end

endmodule

// File: src/lsr_checker.sv
// Port-level checks of the LIFO stack with reverse, bound to the top level.
`include "lifo_stack_with_reverse_top_defines.svh"

module lsr_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          m_tvalid,
	input logic                          m_tready,
	input logic [lsr_pkg::M_TDATA_W-1:0] m_tdata,
	input logic [lsr_pkg::M_TUSER_W-1:0] m_tuser
);

	`LSR_ASSERT_RST(a_no_beat_in_reset, !arst_n |-> (m_tvalid !== 1'b1), "result beat during reset")

	`LSR_ASSERT(a_hold_stalled, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled result beat changed")

	`LSR_ASSERT(a_count_means_valid, m_tvalid && (m_tdata[72:64] != 9'd0) |-> m_tuser[2], "nonzero count without top_valid")

	`LSR_ASSERT(a_empty_top_zero, m_tvalid && !m_tuser[2] |-> (m_tdata[63:32] == 32'd0), "empty stack shows a top value")

	`LSR_ASSERT(a_underflow_clean, m_tvalid && (m_tuser[1:0] == lsr_pkg::ST_UNDERFLOW) |-> (m_tdata[31:0] == 32'd0) && !m_tuser[2], "underflow with data or entries")

endmodule

bind lifo_stack_with_reverse_top lsr_checker u_lsr_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata (m_tdata),
	.m_tuser (m_tuser)
);
